// ===== src/assert_macros.svh =====
// assertion macros shared by the console writer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TCW_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/tcw_pkg.sv =====
// types and constants of the text console character writer
`default_nettype none
package tcw_pkg;

   localparam logic [7:0]  NEWLINE_CODE = 8'd10;
   localparam logic [7:0]  SPACE_CODE   = 8'h20;
   localparam logic [7:0]  BLANK_ATTR   = 8'h07;
   localparam logic [15:0] BLANK_CELL   = {BLANK_ATTR, SPACE_CODE};
   localparam logic [7:0]  ATTR_RESET   = 8'h07;
   localparam logic        OP_WRITE     = 1'b0;
   localparam logic        OP_READ      = 1'b1;
   localparam int unsigned QUEUE_DEPTH  = 2;

   typedef struct packed {
      logic       opcode;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_item_type;

   typedef struct packed {
      logic [15:0] cell_value;
      logic [4:0]  cursor_row_now;
      logic [6:0]  cursor_col_now;
      logic        did_scroll;
   } rsp_item_type;

   typedef enum logic [1:0] {
      CMD_READ,
      CMD_NEWLINE,
      CMD_CHAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   char_code;
      logic [4:0]   read_row;
      logic [6:0]   read_col;
      logic         in_range;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_RUN,
      ST_READ,
      ST_BLANK
   } back_state_type;

endpackage
`default_nettype wire

// ===== src/text_console_char_writer_top.sv =====
// Text console character writer: a ROWS x COLUMNS screen of 16-bit cells and a cursor.
// req channel (req_valid/req_stall/req_item): opcode 0 writes char_code at the
//   cursor (code 10 is a newline), opcode 1 reads the cell at read_row/read_col.
// rsp channel (rsp_valid/rsp_stall/rsp_item): exactly one result per item, in order,
//   holding the read cell (0 for writes or out-of-range reads), the cursor after
//   the item and a scroll flag. A stalled result waits in its output register
//   while the input stage and a two-entry command queue keep taking items.
// csr channel (csr_valid/csr_ready/csr_data): sets the attribute byte of new characters;
//   always ready. The user must write it only while the block is idle: not enforced.
// A write or newline passes the input register, the queue and the output register;
//   a read also passes the registered read port of the screen memory (one port, so a
//   read holds the execution stage in ST_READ); an item that scrolls then blanks the
//   COLUMNS cells of the new bottom row through the single write port.
// Scrolling rotates a row base pointer, so no cell is copied.
// After reset the screen memory is cleared to blanks (space, attribute 0x07) one
//   entry a cycle, ROWS * 2**ceil(log2(COLUMNS)) entries (3200 by default);
//   req_stall is high during that pass. Cursor is at row 0, column 0, attribute is 0x07.
`default_nettype none
module text_console_char_writer_top import tcw_pkg::*; #(
   parameter int unsigned ROWS    = 25,
   parameter int unsigned COLUMNS = 80
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_item,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_data
);

   logic [7:0]   attr_ff, attr_in;
   logic         busy, push, pop;
   cmd_type      push_cmd, q_head;
   q_status_type q_status;

   assign csr_ready = 1'b1;
   assign attr_in   = (csr_valid && csr_ready) ? csr_data : attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   tcw_front #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .busy      (busy),
      .q_status  (q_status),
      .push      (push),
      .cmd       (push_cmd)
   );

   tcw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (q_head),
      .status   (q_status)
   );

   tcw_back #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .attr      (attr_ff),
      .q_status  (q_status),
      .q_head    (q_head),
      .pop       (pop),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

// ===== src/tcw_front.sv =====
// input stage: accepts items, classifies them and hands commands to the queue
`default_nettype none
module tcw_front import tcw_pkg::*; #(
   parameter int unsigned ROWS    = 25,
   parameter int unsigned COLUMNS = 80
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_item,
   input  wire logic         busy,
   input  wire q_status_type q_status,
   output logic              push,
   output cmd_type           cmd
);

   logic    cmd_valid_ff, cmd_valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   always_comb begin
      req_stall    = busy | (cmd_valid_ff & q_status.full);
      accept       = req_valid & ~req_stall;
      push         = cmd_valid_ff & ~q_status.full;
      cmd_valid_in = accept | (cmd_valid_ff & ~push);

      cmd_in           = cmd_ff;
      if (accept) begin
         cmd_in.char_code = req_item.char_code;
         cmd_in.read_row  = req_item.read_row;
         cmd_in.read_col  = req_item.read_col;
         cmd_in.in_range  = (32'(req_item.read_row) < ROWS) &&
                            (32'(req_item.read_col) < COLUMNS);
         priority if (req_item.opcode == OP_READ) begin
            cmd_in.kind = CMD_READ;
         end else if (req_item.char_code == NEWLINE_CODE) begin
            cmd_in.kind = CMD_NEWLINE;
         end else begin
            cmd_in.kind = CMD_CHAR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   assign cmd = cmd_ff;

endmodule
`default_nettype wire

// ===== src/tcw_queue.sv =====
// short command queue between the front and back parts
`default_nettype none
`include "assert_macros.svh"
module tcw_queue import tcw_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head,
   output q_status_type status
);

   localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == CNT_FULL);
      status.empty = (count_ff == '0);
      do_push      = push & ~status.full;
      do_pop       = pop & ~status.empty;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
      head = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `TCW_ASSERT(a_no_push_full, !push || !status.full, "push into a full queue")

endmodule
`default_nettype wire

// ===== src/tcw_back.sv =====
// execution part: screen memory, cursor, scroll base and result register
`default_nettype none
`include "assert_macros.svh"
module tcw_back import tcw_pkg::*; #(
   parameter int unsigned ROWS    = 25,
   parameter int unsigned COLUMNS = 80
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [7:0]   attr,
   input  wire q_status_type q_status,
   input  wire cmd_type      q_head,
   output logic              pop,
   output logic              busy,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_item
);

   localparam int unsigned ROW_BITS  = $clog2(ROWS);
   localparam int unsigned COL_BITS  = $clog2(COLUMNS);
   localparam int unsigned ADDR_BITS = ROW_BITS + COL_BITS;
   localparam int unsigned MEM_DEPTH = ROWS * (1 << COL_BITS);
   localparam logic [ROW_BITS:0]    ROWS_W   = (ROW_BITS + 1)'(ROWS);
   localparam logic [ROW_BITS-1:0]  ROW_LAST = ROW_BITS'(ROWS - 1);
   localparam logic [COL_BITS-1:0]  COL_LAST = COL_BITS'(COLUMNS - 1);
   localparam logic [ADDR_BITS-1:0] ADDR_LAST = ADDR_BITS'(MEM_DEPTH - 1);

   // screen rows live in a circular buffer, row stride is a power of two
   function automatic logic [ROW_BITS-1:0] phys_row(input logic [ROW_BITS-1:0] lrow,
                                                    input logic [ROW_BITS-1:0] base);
      logic [ROW_BITS:0] sum;
      sum = {1'b0, lrow} + {1'b0, base};
      if (sum >= ROWS_W) begin
         sum = sum - ROWS_W;
      end
      return sum[ROW_BITS-1:0];
   endfunction

   logic [15:0] screen_mem_ff [MEM_DEPTH];
   logic [15:0] rd_data_ff;

   back_state_type       state_ff, state_in;
   logic [ROW_BITS-1:0]  cur_row_ff, cur_row_in;
   logic [COL_BITS-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_BITS-1:0]  base_ff, base_in;
   logic [ROW_BITS-1:0]  blank_row_ff, blank_row_in;
   logic [ADDR_BITS-1:0] cnt_ff, cnt_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff, rsp_item_in;

   logic                 mem_we, mem_re;
   logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
   logic [15:0]          mem_wdata;
   logic                 out_free, rsp_load, scroll;
   logic                 row_last, col_last;

   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      base_in      = base_ff;
      blank_row_in = blank_row_ff;
      cnt_in       = cnt_ff;
      rd_ok_in     = rd_ok_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = {phys_row(cur_row_ff, base_ff), cur_col_ff};
      mem_wdata    = BLANK_CELL;
      mem_raddr    = {phys_row(ROW_BITS'(q_head.read_row), base_ff),
                      COL_BITS'(q_head.read_col)};
      rsp_load     = 1'b0;
      scroll       = 1'b0;
      out_free     = ~rsp_valid_ff | ~rsp_stall;
      row_last     = (cur_row_ff == ROW_LAST);
      col_last     = (cur_col_ff == COL_LAST);
      busy         = (state_ff == ST_CLEAR);

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            cnt_in    = cnt_ff + ADDR_BITS'(1);
            if (cnt_ff == ADDR_LAST) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!q_status.empty && out_free) begin
               pop = 1'b1;
               priority if (q_head.kind == CMD_READ) begin
                  mem_re   = 1'b1;
                  rd_ok_in = q_head.in_range;
                  state_in = ST_READ;
               end else begin
                  rsp_load = 1'b1;
                  if (q_head.kind == CMD_CHAR) begin
                     mem_we    = 1'b1;
                     mem_wdata = {attr, q_head.char_code};
                  end
                  if (q_head.kind == CMD_CHAR && !col_last) begin
                     cur_col_in = cur_col_ff + COL_BITS'(1);
                  end else begin
                     // move to the next line, scrolling from the last one
                     cur_col_in = '0;
                     if (row_last) begin
                        scroll       = 1'b1;
                        blank_row_in = base_ff;
                        base_in      = (base_ff == ROW_LAST) ? '0 : base_ff + ROW_BITS'(1);
                        cnt_in       = '0;
                        state_in     = ST_BLANK;
                     end else begin
                        cur_row_in = cur_row_ff + ROW_BITS'(1);
                     end
                  end
               end
            end
         end
         ST_READ: begin
            rsp_load = 1'b1;
            state_in = ST_RUN;
         end
         ST_BLANK: begin
            mem_we    = 1'b1;
            mem_waddr = {blank_row_ff, cnt_ff[COL_BITS-1:0]};
            cnt_in    = cnt_ff + ADDR_BITS'(1);
            if (cnt_ff[COL_BITS-1:0] == COL_LAST) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      rsp_item_in                = rsp_item_ff;
      if (rsp_load) begin
         rsp_item_in.cell_value     = (state_ff == ST_READ && rd_ok_ff) ? rd_data_ff : '0;
         rsp_item_in.cursor_row_now = 5'(cur_row_in);
         rsp_item_in.cursor_col_now = 7'(cur_col_in);
         rsp_item_in.did_scroll     = scroll;
      end
      rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         base_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         base_ff      <= base_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blank_row_ff <= blank_row_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_item_ff  <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= screen_mem_ff[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `TCW_ASSERT(a_pop_nonempty, !pop || !q_status.empty, "pop from empty queue")
   `TCW_ASSERT(a_pos_range, (32'(cur_row_ff) < ROWS) && (32'(base_ff) < ROWS), "row out of range")
   `TCW_ASSERT_NEXT(a_scroll_blank, rsp_load && scroll, state_ff == ST_BLANK, "scroll without blank")
   `TCW_ASSERT(a_scroll_col, !(rsp_valid_ff && rsp_item_ff.did_scroll) || (rsp_item_ff.cursor_col_now == '0), "scroll with cursor off column zero")

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the text console character writer
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tcw_pkg::*;

   localparam int unsigned SCREEN_ROWS = 25;
   localparam int unsigned SCREEN_COLS = 80;
   localparam int unsigned PHASE_ITEMS = 290;
   localparam int unsigned HOLD_CYCLES = 400;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_data = 8'h00;

   // predicted console state
   logic [15:0]  shadow_screen [SCREEN_ROWS][SCREEN_COLS];
   int unsigned  shadow_row;
   int unsigned  shadow_col;
   logic [7:0]   shadow_attr;

   req_item_type req_backlog [$];
   rsp_item_type awaited_rsp [$];

   int unsigned  send_idle_pct = 0;
   int unsigned  rsp_stall_pct = 0;
   logic         hold_armed = 1'b0;
   logic         receiver_hold = 1'b0;
   int unsigned  error_count = 0;

   text_console_char_writer_top #(
      .ROWS   (SCREEN_ROWS),
      .COLUMNS(SCREEN_COLS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // cursor to column 0 of the next row, scrolling up one row past the bottom
   function automatic logic move_to_next_line();
      shadow_col = 0;
      if (shadow_row + 1 < SCREEN_ROWS) begin
         shadow_row++;
         return 1'b0;
      end
      for (int r = 0; r < SCREEN_ROWS - 1; r++)
         for (int c = 0; c < SCREEN_COLS; c++)
            shadow_screen[r][c] = shadow_screen[r + 1][c];
      for (int c = 0; c < SCREEN_COLS; c++)
         shadow_screen[SCREEN_ROWS - 1][c] = BLANK_CELL;
      return 1'b1;
   endfunction

   function automatic rsp_item_type next_console_result(input req_item_type it);
      rsp_item_type r;
      r = '0;
      if (it.opcode == OP_READ) begin
         if (it.read_row < SCREEN_ROWS && it.read_col < SCREEN_COLS)
            r.cell_value = shadow_screen[it.read_row][it.read_col];
      end else if (it.char_code == NEWLINE_CODE) begin
         r.did_scroll = move_to_next_line();
      end else begin
         shadow_screen[shadow_row][shadow_col] = {shadow_attr, it.char_code};
         shadow_col++;
         if (shadow_col >= SCREEN_COLS)
            r.did_scroll = move_to_next_line();
      end
      r.cursor_row_now = 5'(shadow_row);
      r.cursor_col_now = 7'(shadow_col);
      return r;
   endfunction

   function automatic req_item_type make_item(input logic op, input logic [7:0] ch,
                                              input logic [4:0] row, input logic [6:0] col);
      req_item_type it;
      it.opcode    = op;
      it.char_code = ch;
      it.read_row  = row;
      it.read_col  = col;
      return it;
   endfunction

   // mostly characters and newlines with reads near the active rows, some wild reads
   function automatic req_item_type random_item();
      req_item_type it;
      int unsigned  pick;
      it = make_item(OP_WRITE, 8'($urandom_range(255)), 5'($urandom_range(31)),
                     7'($urandom_range(127)));
      pick = $urandom_range(99);
      if (pick < 10) begin
         it.char_code = NEWLINE_CODE;
      end else if (pick < 80) begin
         if (pick >= 70) begin
            it.opcode   = OP_READ;
            it.read_row = 5'($urandom_range(SCREEN_ROWS - 1, SCREEN_ROWS - 4));
            it.read_col = 7'($urandom_range(SCREEN_COLS - 1));
         end
      end else begin
         it.opcode = OP_READ;
         if (pick < 92) begin
            it.read_row = 5'($urandom_range(SCREEN_ROWS - 1));
            it.read_col = 7'($urandom_range(SCREEN_COLS - 1));
         end
      end
      return it;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (error_count < 40)
         $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic wait_until_drained();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || awaited_rsp.size() != 0);
   endtask

   task automatic run_phase(input int unsigned send_pct, input int unsigned stall_pct,
                            input logic [7:0] attr, input logic long_hold);
      wait_until_drained();
      repeat (8) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= attr;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid   <= 1'b0;
      shadow_attr  = attr;
      @(negedge clock);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      if (long_hold)
         hold_armed = 1'b1;
      repeat (PHASE_ITEMS) req_backlog.push_back(random_item());
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            awaited_rsp.push_back(next_console_result(req_item));
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_item  <= req_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch("unexpected item", rsp_item, 0);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_item.cell_value !== want.cell_value)
                  report_mismatch("cell_value", rsp_item.cell_value, want.cell_value);
               if (rsp_item.cursor_row_now !== want.cursor_row_now)
                  report_mismatch("cursor_row_now", rsp_item.cursor_row_now,
                                  want.cursor_row_now);
               if (rsp_item.cursor_col_now !== want.cursor_col_now)
                  report_mismatch("cursor_col_now", rsp_item.cursor_col_now,
                                  want.cursor_col_now);
               if (rsp_item.did_scroll !== want.did_scroll)
                  report_mismatch("did_scroll", rsp_item.did_scroll, want.did_scroll);
            end
         end
         rsp_stall <= receiver_hold || ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // long receiver hold-off so the block backs up and stalls its input
   initial begin
      wait (hold_armed);
      @(posedge clock);
      receiver_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      receiver_hold <= 1'b0;
   end

   initial begin
      #8_000_000;
      $display("[text_console_char_writer_top] ERROR");
      $finish;
   end

   initial begin
      for (int r = 0; r < SCREEN_ROWS; r++)
         for (int c = 0; c < SCREEN_COLS; c++)
            shadow_screen[r][c] = BLANK_CELL;
      shadow_row  = 0;
      shadow_col  = 0;
      shadow_attr = ATTR_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed items at the reset attribute
      req_backlog.push_back(make_item(OP_WRITE, 8'h00, 5'h00, 7'h00));
      req_backlog.push_back(make_item(OP_WRITE, 8'hFF, 5'h1F, 7'h7F));
      req_backlog.push_back(make_item(OP_WRITE, 8'h7F, 5'h00, 7'h00));
      req_backlog.push_back(make_item(OP_WRITE, 8'h80, 5'h1F, 7'h7F));
      req_backlog.push_back(make_item(OP_READ, 8'h00, 5'd0, 7'd0));
      req_backlog.push_back(make_item(OP_READ, NEWLINE_CODE, 5'd0, 7'd1));
      req_backlog.push_back(make_item(OP_READ, 8'hFF, 5'd0, 7'd3));
      req_backlog.push_back(make_item(OP_WRITE, NEWLINE_CODE, 5'h00, 7'h00));
      req_backlog.push_back(make_item(OP_WRITE, 8'h55, 5'h0A, 7'h2A));
      req_backlog.push_back(make_item(OP_WRITE, 8'hAA, 5'h15, 7'h55));
      req_backlog.push_back(make_item(OP_WRITE, NEWLINE_CODE, 5'h1F, 7'h7F));
      req_backlog.push_back(make_item(OP_READ, 8'h00, 5'd1, 7'd0));
      req_backlog.push_back(make_item(OP_READ, 8'h00, 5'd1, 7'd1));
      req_backlog.push_back(make_item(OP_READ, 8'h00, 5'd0, 7'd79));
      req_backlog.push_back(make_item(OP_READ, 8'h00, 5'd24, 7'd0));
      req_backlog.push_back(make_item(OP_READ, 8'h00, 5'd24, 7'd79));
      // reads outside the screen
      req_backlog.push_back(make_item(OP_READ, 8'h00, 5'd25, 7'd0));
      req_backlog.push_back(make_item(OP_READ, 8'h00, 5'd0, 7'd80));
      req_backlog.push_back(make_item(OP_READ, 8'h00, 5'd25, 7'd79));
      req_backlog.push_back(make_item(OP_READ, 8'h00, 5'd24, 7'd80));
      req_backlog.push_back(make_item(OP_READ, 8'hFF, 5'd31, 7'd127));

      run_phase(0, 0, 8'h00, 1'b0);
      run_phase(48, 0, 8'hFF, 1'b0);
      run_phase(0, 48, 8'($urandom_range(255)), 1'b0);
      run_phase(24, 24, 8'($urandom_range(255)), 1'b0);
      run_phase(0, 0, 8'hA5, 1'b1);
      run_phase(24, 24, 8'($urandom_range(255)), 1'b0);

      wait_until_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0 && awaited_rsp.size() == 0)
         $display("[text_console_char_writer_top] OK");
      else
         $display("[text_console_char_writer_top] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/tcw_pkg.sv
src/tcw_front.sv
src/tcw_queue.sv
src/tcw_back.sv
src/text_console_char_writer_top.sv
tb/sv/testbench.sv
